// File: sv/tws_pkg.sv
// Package with shared types, codes and conversion helpers for the temperature window statistics.
`timescale 1ns / 1ps

package tws_pkg;

	localparam int ADC_W = 12;
	localparam int TEMP_W = 8;
	localparam int FILL_W = 6;
	localparam int SCALE_W = 9;
	localparam int PROD_W = ADC_W + SCALE_W;
	localparam int SCALE_SHIFT = 12;

	// Full-scale reference of 3.30 V in hundredths of a degree step.
	localparam logic [SCALE_W-1:0] SCALE_MULT = 9'd330;
	localparam logic [TEMP_W-1:0] DEG_SAT = 8'd255;
	localparam logic [TEMP_W-1:0] MIN_RESET = 8'd255;
	localparam logic [TEMP_W-1:0] MAX_RESET = 8'd0;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_CLEAR  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic ram_we;
		logic div_step;
		logic load_out;
	} ctrl_t;

	// Converts a raw code to whole degrees, floor(code * 330 / 4096), saturated.
	function automatic logic [TEMP_W-1:0] to_degrees(input logic [ADC_W-1:0] code);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-SCALE_SHIFT-1:0] deg;
		prod = PROD_W'(code) * PROD_W'(SCALE_MULT);
		deg = prod[PROD_W-1:SCALE_SHIFT];
		if (deg > (PROD_W - SCALE_SHIFT)'(DEG_SAT)) begin
			return DEG_SAT;
		end
		return deg[TEMP_W-1:0];
	endfunction

endpackage

// File: sv/tws_sample_if.sv
// Request channel carrying one sample or clear command.
`timescale 1ns / 1ps

interface tws_sample_if;
	logic valid;
	logic ready;
	logic func;
	logic [tws_pkg::ADC_W-1:0] adc_code;

	modport source (output valid, output func, output adc_code, input ready);
	modport sink (input valid, input func, input adc_code, output ready);
endinterface

// File: sv/tws_result_if.sv
// Result channel carrying the statistics reported for each request.
`timescale 1ns / 1ps

interface tws_result_if;
	logic valid;
	logic ready;
	logic [tws_pkg::TEMP_W-1:0] current_temp;
	logic [tws_pkg::TEMP_W-1:0] average_temp;
	logic [tws_pkg::TEMP_W-1:0] max_temp;
	logic [tws_pkg::TEMP_W-1:0] min_temp;
	logic [tws_pkg::FILL_W-1:0] fill_count;

	modport source (output valid, output current_temp, output average_temp, output max_temp,
		output min_temp, output fill_count, input ready);
	modport sink (input valid, input current_temp, input average_temp, input max_temp,
		input min_temp, input fill_count, output ready);
endinterface

// File: sv/temperature_window_statistics_unit.sv
// Top level of the temperature window statistics unit.
`timescale 1ns / 1ps
// Usage: requests arrive on the samples channel (valid/ready). A request with func set to
// sample carries a 12-bit sensor code; it is converted to whole degrees, stored in a circular
// window of the last WINDOW_DEPTH values, and one result is returned on the results channel:
// current temperature, truncated window mean, running max and min, and the window fill count.
// A request with func set to clear empties the window and returns 0/0/0/255/0.
// Sequence: the oldest window entry is read from the RAM as a sample request is accepted,
// the update state writes the new value and updates sum, count, max and min, and the divide
// state runs the restoring divider that forms the mean one quotient bit per cycle; the done
// state loads the result once the output register is free. A clear request goes straight to
// the done state. Only one request is in flight at a time.
// The result sits in an output register, so a new request is taken while an earlier result
// still waits; if the receiver stalls, the finished next result waits in the block until the
// output register frees, and no further request is accepted meanwhile.
// Reset: arst_n clears the window pointer, fill count, sum, max (0) and min (255). The window
// RAM itself is not cleared; entries are only used once the fill count shows they were written.

module temperature_window_statistics_unit #(
	parameter int WINDOW_DEPTH = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	tws_sample_if.sink          samples,
	tws_result_if.source        results
);

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = $clog2(WINDOW_DEPTH * 255 + 1);
	// The mean never exceeds 255, so the divisor shifted by up to 7 fits here.
	localparam int DIV_W = CNT_W + tws_pkg::TEMP_W;
	localparam int BIT_W = $clog2(tws_pkg::TEMP_W);

	tws_pkg::state_t state_q, state_next;
	tws_pkg::ctrl_t  ctrl;

	logic [PTR_W-1:0]           wptr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [SUM_W-1:0]           sum_q;
	logic [tws_pkg::TEMP_W-1:0] max_q;
	logic [tws_pkg::TEMP_W-1:0] min_q;
	logic [tws_pkg::TEMP_W-1:0] cur_q;

	// Divider state: partial remainder, quotient and the quotient bit being decided.
	logic [SUM_W-1:0]           rem_q;
	logic [tws_pkg::TEMP_W-1:0] quo_q;
	logic [BIT_W-1:0]           bit_q;

	logic                       out_valid_q;
	logic                       accept;
	logic                       is_clear;
	logic                       out_free;
	logic                       full;
	logic [tws_pkg::TEMP_W-1:0] ram_rdata;
	logic [tws_pkg::TEMP_W-1:0] oldest;
	logic [SUM_W-1:0]           sum_next;
	logic [CNT_W-1:0]           cnt_next;
	logic [PTR_W-1:0]           wptr_next;
	logic [DIV_W-1:0]           trial;
	logic [DIV_W-1:0]           rem_ext;
	logic                       take;
	logic [CNT_W+tws_pkg::FILL_W-1:0] cnt_wide;

	assign accept   = samples.valid && samples.ready;
	assign is_clear = (samples.func == tws_pkg::FUNC_CLEAR);
	assign out_free = !out_valid_q || results.ready;
	assign samples.ready = ctrl.in_ready;

	// The window RAM holds one converted temperature per slot.
	tws_ram #(
		.WIDTH (tws_pkg::TEMP_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (wptr_q),
		.wdata (cur_q),
		.raddr (wptr_q),
		.rdata (ram_rdata)
	);

	// Once the window is full, the slot about to be overwritten holds the oldest sample,
	// whose value leaves the sum.
	assign full      = (cnt_q == CNT_W'(WINDOW_DEPTH));
	assign oldest    = full ? ram_rdata : '0;
	assign sum_next  = sum_q - SUM_W'(oldest) + SUM_W'(cur_q);
	assign cnt_next  = full ? cnt_q : cnt_q + 1'b1;
	assign wptr_next = (wptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wptr_q + 1'b1;

	// Restoring division step: try to subtract count shifted to the current quotient bit.
	assign trial   = DIV_W'(cnt_q) << bit_q;
	assign rem_ext = DIV_W'(rem_q);
	assign take    = (rem_ext >= trial);

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			tws_pkg::ST_IDLE: begin
				if (samples.valid) begin
					state_next = is_clear ? tws_pkg::ST_DONE : tws_pkg::ST_UPDATE;
				end
			end
			tws_pkg::ST_UPDATE: begin
				state_next = tws_pkg::ST_DIVIDE;
			end
			tws_pkg::ST_DIVIDE: begin
				if (bit_q == '0) begin
					state_next = tws_pkg::ST_DONE;
				end
			end
			tws_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = tws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = tws_pkg::ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		ctrl = '0;
		case (state_q)
			tws_pkg::ST_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			tws_pkg::ST_UPDATE: begin
				ctrl.ram_we = 1'b1;
			end
			tws_pkg::ST_DIVIDE: begin
				ctrl.div_step = 1'b1;
			end
			tws_pkg::ST_DONE: begin
				ctrl.load_out = out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tws_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Window bookkeeping and running extremes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			max_q  <= tws_pkg::MAX_RESET;
			min_q  <= tws_pkg::MIN_RESET;
		end else if (accept && is_clear) begin
			wptr_q <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			max_q  <= tws_pkg::MAX_RESET;
			min_q  <= tws_pkg::MIN_RESET;
		end else if (ctrl.ram_we) begin
			wptr_q <= wptr_next;
			cnt_q  <= cnt_next;
			sum_q  <= sum_next;
			if (cur_q > max_q) begin
				max_q <= cur_q;
			end
			if (cur_q < min_q) begin
				min_q <= cur_q;
			end
		end
	end

	// Converted sample and divider datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= is_clear ? '0 : tws_pkg::to_degrees(samples.adc_code);
			quo_q <= '0;
		end else if (ctrl.ram_we) begin
			rem_q <= sum_next;
			quo_q <= '0;
			bit_q <= BIT_W'(tws_pkg::TEMP_W - 1);
		end else if (ctrl.div_step) begin
			if (take) begin
				rem_q        <= SUM_W'(rem_ext - trial);
				quo_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cnt_wide = (CNT_W + tws_pkg::FILL_W)'(cnt_q);

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			results.current_temp <= cur_q;
			results.average_temp <= quo_q;
			results.max_temp     <= max_q;
			results.min_temp     <= min_q;
			results.fill_count   <= cnt_wide[tws_pkg::FILL_W-1:0];
		end
	end

	assign results.valid = out_valid_q;

	// The fill count never passes the window depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count exceeds window depth");

	// An accepted request always starts the sequencer.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != tws_pkg::ST_IDLE)
		else $error("accepted request did not start processing");

	// A loaded result is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> results.valid)
		else $error("loaded result not presented");

	// With samples in the window, the maximum is never below the minimum.
	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> max_q >= min_q)
		else $error("running max below running min");

endmodule

// File: sv/tws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 50
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: test/testbench.sv
// Self-checking testbench for the temperature window statistics unit.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH = 50;
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_ITEMS = 150;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_AFTER = 400;
	localparam int DRAIN_CYCLES = 25;
	localparam int REPORT_LIMIT = 10;
	localparam int RUN_LIMIT_NS = 3_000_000;

	typedef struct packed {
		logic [tws_pkg::TEMP_W-1:0] current_temp;
		logic [tws_pkg::TEMP_W-1:0] average_temp;
		logic [tws_pkg::TEMP_W-1:0] max_temp;
		logic [tws_pkg::TEMP_W-1:0] min_temp;
		logic [tws_pkg::FILL_W-1:0] fill_count;
	} temp_stats_t;

	typedef struct {
		tws_pkg::func_t f;
		logic [tws_pkg::ADC_W-1:0] code;
		bit typed;
		temp_stats_t want;
	} stim_row_t;

	localparam temp_stats_t CLEARED_STATS = {8'd0, 8'd0, tws_pkg::MAX_RESET,
		tws_pkg::MIN_RESET, 6'd0};

	logic clk = 1'b0;
	logic arst_n;

	tws_sample_if samples ();
	tws_result_if results ();

	temperature_window_statistics_unit #(
		.WINDOW_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results)
	);

	always #5 clk = ~clk;

	// Shadow copy of the window and the running statistics.
	logic [tws_pkg::TEMP_W-1:0] win_vals [DEPTH];
	int unsigned win_ptr;
	int unsigned win_fill;
	int unsigned win_sum;
	logic [tws_pkg::TEMP_W-1:0] run_max;
	logic [tws_pkg::TEMP_W-1:0] run_min;

	temp_stats_t pending_stats_q [$];
	stim_row_t directed_rows [$];
	int requests_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	bit quiet = 1'b0;
	bit long_hold_done = 1'b0;
	temp_stats_t observed;
	temp_stats_t wanted;

	// Updates the shadow state for one request and returns the statistics it reports.
	function automatic temp_stats_t predict_stats(input tws_pkg::func_t f,
			input logic [tws_pkg::ADC_W-1:0] code);
		temp_stats_t r;
		int unsigned scaled;
		logic [tws_pkg::TEMP_W-1:0] deg;
		if (f == tws_pkg::FUNC_CLEAR) begin
			foreach (win_vals[i]) win_vals[i] = '0;
			win_ptr = 0;
			win_fill = 0;
			win_sum = 0;
			run_max = tws_pkg::MAX_RESET;
			run_min = tws_pkg::MIN_RESET;
			return CLEARED_STATS;
		end
		scaled = (int'(code) * 330) >> 12;
		deg = (scaled > 255) ? tws_pkg::DEG_SAT : tws_pkg::TEMP_W'(scaled);
		// A full window drops its oldest value from the sum before the new one lands.
		if (win_fill >= DEPTH) begin
			win_sum = win_sum - win_vals[win_ptr];
		end else begin
			win_fill = win_fill + 1;
		end
		win_vals[win_ptr] = deg;
		win_sum = win_sum + deg;
		win_ptr = (win_ptr + 1) % DEPTH;
		if (deg > run_max) run_max = deg;
		if (deg < run_min) run_min = deg;
		r.current_temp = deg;
		r.average_temp = tws_pkg::TEMP_W'(win_sum / win_fill);
		r.max_temp = run_max;
		r.min_temp = run_min;
		r.fill_count = tws_pkg::FILL_W'(win_fill);
		return r;
	endfunction

	task automatic table_row(input tws_pkg::func_t f, input logic [tws_pkg::ADC_W-1:0] code,
			input bit typed, input temp_stats_t want);
		stim_row_t row;
		row.f = f;
		row.code = code;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Offers one request, holds it until taken, then records what it should report.
	task automatic issue_request(input tws_pkg::func_t f,
			input logic [tws_pkg::ADC_W-1:0] code, input bit typed,
			input temp_stats_t typed_want);
		temp_stats_t model_want;
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			samples.valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.func <= f;
		samples.adc_code <= code;
		do @(posedge clk); while (samples.ready !== 1'b1);
		model_want = predict_stats(f, code);
		pending_stats_q.push_back(typed ? typed_want : model_want);
		requests_sent++;
	endtask

	initial begin : stimulus
		int total;
		int run_len;
		int style;
		int base;
		int val;
		logic [tws_pkg::ADC_W-1:0] code;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.func = tws_pkg::FUNC_SAMPLE;
		samples.adc_code = '0;
		void'(predict_stats(tws_pkg::FUNC_CLEAR, '0));

		// Extremes of the conversion, saturation edge, truncation edge and clears.
		table_row(tws_pkg::FUNC_SAMPLE, 12'd0, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 6'd1});
		table_row(tws_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, {8'd255, 8'd127, 8'd255, 8'd0, 6'd2});
		table_row(tws_pkg::FUNC_CLEAR, 12'd0, 1'b1, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd4095, 1'b1, {8'd255, 8'd255, 8'd255, 8'd255, 6'd1});
		table_row(tws_pkg::FUNC_SAMPLE, 12'd3178, 1'b1, {8'd255, 8'd255, 8'd255, 8'd255, 6'd2});
		table_row(tws_pkg::FUNC_SAMPLE, 12'd3177, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd3165, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd12, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd13, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd2048, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_CLEAR, 12'd4095, 1'b1, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd1, 1'b1, {8'd0, 8'd0, 8'd0, 8'd0, 6'd1});
		table_row(tws_pkg::FUNC_CLEAR, 12'hAAA, 1'b1, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'h555, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'hAAA, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'hFFF, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_CLEAR, 12'h555, 1'b1, CLEARED_STATS);
		table_row(tws_pkg::FUNC_SAMPLE, 12'd2048, 1'b1, {8'd165, 8'd165, 8'd165, 8'd165, 6'd1});
		table_row(tws_pkg::FUNC_SAMPLE, 12'd1024, 1'b0, CLEARED_STATS);
		table_row(tws_pkg::FUNC_CLEAR, 12'd0, 1'b1, CLEARED_STATS);
		table_row(tws_pkg::FUNC_CLEAR, 12'hFFF, 1'b1, CLEARED_STATS);
		total = directed_rows.size() + RANDOM_ITEMS;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			issue_request(directed_rows[i].f, directed_rows[i].code, directed_rows[i].typed,
				directed_rows[i].want);
		end

		// Random part: clears followed by runs of samples, often long enough to wrap the window.
		while (requests_sent < total) begin
			run_len = $urandom_range(1, 3 * DEPTH);
			style = $urandom_range(0, 3);
			base = $urandom_range(0, 4095);
			quiet = (requests_sent >= total - QUIET_ITEMS);
			issue_request(tws_pkg::FUNC_CLEAR, tws_pkg::ADC_W'($urandom), 1'b0, CLEARED_STATS);
			for (int k = 0; k < run_len && requests_sent < total; k++) begin
				quiet = (requests_sent >= total - QUIET_ITEMS);
				case (style)
					0: code = tws_pkg::ADC_W'($urandom_range(0, 4095));
					1: begin
						// Slowly drifting reading around a base value.
						base = base + $urandom_range(0, 16) - 8;
						val = base + $urandom_range(0, 60) - 30;
						if (val < 0) val = 0;
						if (val > 4095) val = 4095;
						code = tws_pkg::ADC_W'(val);
					end
					2: code = tws_pkg::ADC_W'($urandom_range(3100, 4095));
					default: code = tws_pkg::ADC_W'($urandom_range(0, 64));
				endcase
				if ($urandom_range(0, 59) == 0) begin
					issue_request(tws_pkg::FUNC_CLEAR, code, 1'b0, CLEARED_STATS);
				end else begin
					issue_request(tws_pkg::FUNC_SAMPLE, code, 1'b0, CLEARED_STATS);
				end
			end
		end
		samples.valid <= 1'b0;

		while (pending_stats_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_stats_q.size() == 0) begin
			$display("temperature_window_statistics_unit: match");
		end else begin
			$display("temperature_window_statistics_unit: mismatch");
		end
		$finish;
	end

	// Result receiver: short random stalls, one long hold that backs the block up into its
	// request side, and a steady ready during the final stretch.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && results_checked >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1) begin
			observed.current_temp = results.current_temp;
			observed.average_temp = results.average_temp;
			observed.max_temp = results.max_temp;
			observed.min_temp = results.min_temp;
			observed.fill_count = results.fill_count;
			if (pending_stats_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("extra result at %0t: cur %0d avg %0d max %0d min %0d fill %0d",
						$realtime, observed.current_temp, observed.average_temp,
						observed.max_temp, observed.min_temp, observed.fill_count);
				end
			end else begin
				wanted = pending_stats_q.pop_front();
				if (observed.current_temp !== wanted.current_temp ||
						observed.average_temp !== wanted.average_temp ||
						observed.max_temp !== wanted.max_temp ||
						observed.min_temp !== wanted.min_temp ||
						observed.fill_count !== wanted.fill_count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("result %0d at %0t, expected/actual:",
							results_checked, $realtime);
						$display("  cur %0d/%0d avg %0d/%0d max %0d/%0d min %0d/%0d fill %0d/%0d",
							wanted.current_temp, observed.current_temp,
							wanted.average_temp, observed.average_temp,
							wanted.max_temp, observed.max_temp,
							wanted.min_temp, observed.min_temp,
							wanted.fill_count, observed.fill_count);
					end
				end
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("temperature_window_statistics_unit: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
sv/tws_pkg.sv
sv/tws_sample_if.sv
sv/tws_result_if.sv
sv/tws_ram.sv
sv/temperature_window_statistics_unit.sv
test/testbench.sv
